/* hw/rtl/pmm_pkg.sv */
package pmm_pkg;

    localparam int MAX_DEGREE = 15;
    localparam int COEFF_BITS = 16;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int DEG_W      = 4;
    localparam int POW_W      = 5;
    localparam int PROD_W     = 2 * COEFF_BITS;
    localparam int ACC_W      = PROD_W + IDX_W;
    localparam int MODULUS_W  = 16;
    localparam int PADDR_W    = 3;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = MODULUS_W'(2);

    typedef enum logic
    {
        REG_MODULUS = 1'b0,
        REG_DEGREE  = 1'b1
    } reg_sel_t;

    typedef struct packed
    {
        logic load;
        logic rot;
    } cell_ctl_t;

endpackage

/* hw/rtl/pmm_cell.sv */
module pmm_cell
    import pmm_pkg::*;
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [COEFF_BITS-1:0] a_prev,
    input  logic [COEFF_BITS-1:0] b_prev,
    input  logic [COEFF_BITS-1:0] a_nxt,
    output logic [COEFF_BITS-1:0] a,
    output logic [COEFF_BITS-1:0] b
);

    logic [COEFF_BITS-1:0] a_reg;
    logic [COEFF_BITS-1:0] b_reg;

    // load shifts up the line, rot turns the a line toward cell 0
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= a_prev;
            b_reg <= b_prev;
        end
        else if (ctl.rot)
        begin
            a_reg <= a_nxt;
        end
    end

    assign a = a_reg;
    assign b = b_reg;

endmodule

/* hw/rtl/pmm_mod.sv */
module pmm_mod
    import pmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ACC_W-1:0]     dividend,
    input  logic [MODULUS_W-1:0] modulus,
    output logic                 done,
    output logic [MODULUS_W-1:0] rem
);

    localparam int CNT_W = $clog2(ACC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ACC_W-1:0]     sh_reg;
    logic [MODULUS_W-1:0] rem_reg;
    logic [MODULUS_W:0]   trial;
    logic [MODULUS_W-1:0] rem_next;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        trial = {rem_reg, sh_reg[ACC_W-1]};
        if (trial >= {1'b0, modulus})
        begin
            trial = trial - {1'b0, modulus};
        end
        rem_next = trial[MODULUS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            sh_reg  <= {sh_reg[ACC_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* hw/rtl/poly_mul_mod_prime_unit.sv */
// Polynomial multiply modulo a prime.
// Config: APB-style port, modulus at 0x0, degree at 0x4; write only while idle.
// A degree write drops any partial run.
// Input: a beat is taken when start is high and busy is low. Send degree+1
// beats, highest coefficient first; each shifts into a line of cells.
// The beat for degree zero ends the run and raises busy.
// Output: 2*degree+1 beats on power/coeff/last, each marked by valid for one
// cycle, highest power first, last on power zero. No backpressure.
// Flow: after a non-final beat the unit stays idle for the next one. For each
// product coefficient the a line rotates once through one multiplier in a
// multiply-accumulate pass, then the sum goes through the bit-serial remainder
// unit; busy drops as the power-zero beat is shown.
// Reset: modulus 2, degree 0, run count cleared, no result pending; stored
// coefficients are not cleared.
module poly_mul_mod_prime_unit
    import pmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [COEFF_BITS-1:0] a_coeff,
    input  logic [COEFF_BITS-1:0] b_coeff,
    output logic                  valid,
    output logic [POW_W-1:0]      power,
    output logic [COEFF_BITS-1:0] coeff,
    output logic                  last
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_MODW
    } state_t;

    localparam logic [IDX_W-1:0] R_LAST = IDX_W'(DEPTH - 1);

    state_t                state_reg;
    logic [MODULUS_W-1:0]  modulus_reg;
    logic [DEG_W-1:0]      degree_reg;
    logic [POW_W-1:0]      cnt_reg;
    logic [POW_W-1:0]      p_reg;
    logic [IDX_W-1:0]      r_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  pv_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  valid_reg;
    logic [POW_W-1:0]      power_reg;
    logic [COEFF_BITS-1:0] coeff_reg;
    logic                  last_reg;

    logic                  wr;
    logic                  accept;
    logic [COEFF_BITS-1:0] a_line [DEPTH];
    logic [COEFF_BITS-1:0] b_line [DEPTH];
    cell_ctl_t             ctl;
    logic [POW_W:0]        diff;
    logic                  term_ok;
    logic [ACC_W-1:0]      acc_sum;
    logic                  mod_start;
    logic                  mod_done;
    logic [MODULUS_W-1:0]  mod_rem;
    logic [DEG_W-1:0]      d;

    assign d      = degree_reg;
    assign wr     = psel && penable && pwrite;
    assign accept = start && (state_reg == ST_IDLE);
    assign pready = 1'b1;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        unique case (reg_sel_t'(paddr[2]))
            REG_MODULUS: prdata = {{(32-MODULUS_W){1'b0}}, modulus_reg};
            REG_DEGREE:  prdata = {{(32-DEG_W){1'b0}}, degree_reg};
            default:     prdata = '0;
        endcase
    end

    assign ctl.load = accept;
    assign ctl.rot  = (state_reg == ST_MAC);

    generate
        for (genvar k = 0; k < DEPTH; k++)
        begin : g_cell
            pmm_cell u_cell
            (
                .clk    (clk),
                .ctl    (ctl),
                .a_prev ((k == 0) ? a_coeff : a_line[(k + DEPTH - 1) % DEPTH]),
                .b_prev ((k == 0) ? b_coeff : b_line[(k + DEPTH - 1) % DEPTH]),
                .a_nxt  (a_line[(k + 1) % DEPTH]),
                .a      (a_line[k]),
                .b      (b_line[k])
            );
        end
    endgenerate

    // cell 0 holds a[r]; pair it with b[p-r] when that index is in range
    always_comb
    begin
        diff    = {1'b0, p_reg} - {{(POW_W+1-IDX_W){1'b0}}, r_reg};
        term_ok = ({1'b0, r_reg} <= {1'b0, d})
                  && (p_reg >= {{(POW_W-IDX_W){1'b0}}, r_reg})
                  && (diff[POW_W-1:0] <= {{(POW_W-DEG_W){1'b0}}, d});
        acc_sum = acc_reg + (pv_reg ? {{IDX_W{1'b0}}, prod_reg} : '0);
    end

    assign mod_start = (state_reg == ST_DRAIN);

    pmm_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (acc_sum),
        .modulus  (modulus_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= a_line[0] * b_line[diff[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            modulus_reg <= MODULUS_RESET;
            degree_reg  <= '0;
            cnt_reg     <= '0;
            p_reg       <= '0;
            r_reg       <= '0;
            pv_reg      <= 1'b0;
            acc_reg     <= '0;
            valid_reg   <= 1'b0;
            power_reg   <= '0;
            coeff_reg   <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            pv_reg    <= 1'b0;
            if (wr)
            begin
                unique case (reg_sel_t'(paddr[2]))
                    REG_MODULUS: modulus_reg <= pwdata[MODULUS_W-1:0];
                    REG_DEGREE:
                    begin
                        degree_reg <= pwdata[DEG_W-1:0];
                        cnt_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cnt_reg == {1'b0, d})
                        begin
                            cnt_reg   <= '0;
                            p_reg     <= {d, 1'b0};
                            r_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= ST_MAC;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_MAC:
                begin
                    pv_reg  <= term_ok;
                    acc_reg <= acc_sum;
                    r_reg   <= r_reg + 1'b1;
                    if (r_reg == R_LAST)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_MODW;
                end
                ST_MODW:
                begin
                    if (mod_done)
                    begin
                        valid_reg <= 1'b1;
                        power_reg <= p_reg;
                        coeff_reg <= (modulus_reg < MODULUS_RESET) ? '0 : mod_rem;
                        last_reg  <= (p_reg == '0);
                        acc_reg   <= '0;
                        r_reg     <= '0;
                        if (p_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            p_reg     <= p_reg - 1'b1;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign valid = valid_reg;
    assign power = power_reg;
    assign coeff = coeff_reg;
    assign last  = last_reg;

endmodule

/* verif/poly_mul_mod_prime_unit_test.sv */
module poly_mul_mod_prime_unit_test;
    import pmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [POW_W-1:0]      power;
        logic [COEFF_BITS-1:0] coeff;
        logic                  last;
    } product_beat_t;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [COEFF_BITS-1:0] a_coeff;
    logic [COEFF_BITS-1:0] b_coeff;
    logic                  valid;
    logic [POW_W-1:0]      power;
    logic [COEFF_BITS-1:0] coeff;
    logic                  last;

    logic [MODULUS_W-1:0]  model_modulus;
    logic [DEG_W-1:0]      model_degree;
    int unsigned           model_pairs;
    logic [COEFF_BITS-1:0] a_store [DEPTH];
    logic [COEFF_BITS-1:0] b_store [DEPTH];
    product_beat_t         pending_products [$];
    int unsigned           error_count;
    int unsigned           cycle_count;
    int unsigned           burst_left;

    poly_mul_mod_prime_unit dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("poly_mul_mod_prime_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        product_beat_t got;
        product_beat_t want;
        if (rst_n && valid)
        begin
            got = '{power: power, coeff: coeff, last: last};
            if (pending_products.size() == 0)
            begin
                $display("%0t unexpected beat: expected none, actual %p", $realtime, got);
                error_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                if (got.power !== want.power)
                begin
                    $display("%0t power: expected %0d, actual %0d", $realtime,
                             want.power, got.power);
                    error_count++;
                end
                if (got.coeff !== want.coeff)
                begin
                    $display("%0t coeff: expected %0d, actual %0d", $realtime,
                             want.coeff, got.coeff);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t last: expected %0d, actual %0d", $realtime,
                             want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    function automatic void predict_products(logic [COEFF_BITS-1:0] a,
                                             logic [COEFF_BITS-1:0] b);
        int unsigned   d;
        int unsigned   slot;
        longint unsigned acc;
        product_beat_t beat;
        d = model_degree;
        if (model_pairs > d)
            model_pairs = 0;
        slot = d - model_pairs;
        a_store[slot] = a;
        b_store[slot] = b;
        model_pairs++;
        if (model_pairs <= d)
            return;
        model_pairs = 0;
        for (int p = 2 * d; p >= 0; p--)
        begin
            acc = 0;
            if (model_modulus >= 2)
            begin
                for (int i = 0; i <= d; i++)
                    if (p - i >= 0 && p - i <= d)
                        acc += (longint'(a_store[i]) * longint'(b_store[p - i]))
                               % model_modulus;
                acc = acc % model_modulus;
            end
            beat.power = POW_W'(p);
            beat.coeff = COEFF_BITS'(acc);
            beat.last  = (p == 0);
            pending_products.push_back(beat);
        end
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_products.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(reg_sel_t sel, logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(sel) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == REG_MODULUS)
            model_modulus = value[MODULUS_W-1:0];
        else
        begin
            model_degree = value[DEG_W-1:0];
            model_pairs  = 0;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input beat; caller chooses whether gaps are inserted
    task automatic send_pair(logic [COEFF_BITS-1:0] a, logic [COEFF_BITS-1:0] b,
                             bit gaps);
        int unsigned gap;
        gap = 0;
        if (gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        a_coeff <= a;
        b_coeff <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_products(a, b);
        @(negedge clk);
    endtask

    task automatic test_extremes();
        write_reg(REG_MODULUS, 32'd65521);
        write_reg(REG_DEGREE, 32'd0);
        send_pair(16'd0, 16'd0, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'd65520, 16'd65520, 1'b0);
        write_reg(REG_DEGREE, 32'd2);
        send_pair(16'd1, 16'd2, 1'b0);
        send_pair(16'd3, 16'd4, 1'b0);
        send_pair(16'd5, 16'd6, 1'b0);
        write_reg(REG_MODULUS, 32'd65535);
        write_reg(REG_DEGREE, 32'd15);
        for (int i = 0; i < 16; i++)
            send_pair(COEFF_BITS'(16'hFFFF - i), 16'hFFFE, 1'b0);
    endtask

    task automatic test_special_moduli();
        write_reg(REG_DEGREE, 32'd1);
        write_reg(REG_MODULUS, 32'd0);
        send_pair(16'd7, 16'd9, 1'b0);
        send_pair(16'd11, 16'd13, 1'b0);
        write_reg(REG_MODULUS, 32'd1);
        send_pair(16'd7, 16'd9, 1'b0);
        send_pair(16'd11, 16'd13, 1'b0);
        write_reg(REG_MODULUS, 32'd12);
        send_pair(16'd40, 16'd33, 1'b0);
        send_pair(16'hFFFF, 16'd5, 1'b0);
    endtask

    task automatic test_abandoned_run();
        write_reg(REG_MODULUS, 32'd97);
        write_reg(REG_DEGREE, 32'd3);
        send_pair(16'd1, 16'd1, 1'b0);
        send_pair(16'd2, 16'd2, 1'b0);
        write_reg(REG_DEGREE, 32'd1);
        send_pair(16'd50, 16'd60, 1'b0);
        send_pair(16'd70, 16'd80, 1'b0);
    endtask

    task automatic test_random_runs();
        int unsigned sent;
        int unsigned d;
        int unsigned m;
        sent = 0;
        while (sent < 400)
        begin
            case ($urandom_range(0, 4))
                0: m = 65535;
                1: m = $urandom_range(2, 20);
                2: m = 65521;
                default: m = $urandom_range(0, 65535);
            endcase
            write_reg(REG_MODULUS, m);
            d = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
            write_reg(REG_DEGREE, d);
            for (int r = 0; r < $urandom_range(1, 4); r++)
            begin
                for (int k = 0; k <= d; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_pair(COEFF_BITS'($urandom), COEFF_BITS'($urandom), 1'b1);
                    else
                        send_pair(COEFF_BITS'($urandom_range(0, m > 0 ? m - 1 : 0)),
                                  COEFF_BITS'($urandom_range(0, m > 0 ? m - 1 : 0)),
                                  1'b1);
                    sent++;
                end
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send_pair(COEFF_BITS'($urandom), COEFF_BITS'($urandom), 1'b1);
                sent++;
            end
        end
    endtask

    initial
    begin
        cycle_count  = 0;
        error_count  = 0;
        burst_left   = 0;
        model_modulus = MODULUS_RESET;
        model_degree  = '0;
        model_pairs   = 0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        a_coeff = '0;
        b_coeff = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_special_moduli();
        test_abandoned_run();
        test_random_runs();
        wait_idle();
        if (error_count == 0)
            $display("poly_mul_mod_prime_unit: match");
        else
            $display("poly_mul_mod_prime_unit: mismatch");
        $finish;
    end

endmodule
